FILE: design/skq_pkg.sv
package skq_pkg;

  localparam int unsigned OP_W = 2;
  localparam int unsigned ST_W = 2;
  localparam int unsigned ID_W = 32;
  localparam int unsigned KEY_W = 16;
  localparam int unsigned HOUR_W = 5;
  localparam int unsigned MIN_W = 6;
  localparam int unsigned PASS_W = 10;
  localparam int unsigned FUEL_W = 16;

  localparam int unsigned IN_FIELDS_W = ID_W + KEY_W + HOUR_W + MIN_W + PASS_W + FUEL_W;
  localparam int unsigned IN_DATA_W = ((IN_FIELDS_W + 7) / 8) * 8;

  localparam logic [OP_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [OP_W-1:0] CMD_POP    = 2'd1;
  localparam logic [OP_W-1:0] CMD_REMOVE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

  // id sits in the lowest bits
  typedef struct packed {
    logic              emergency;
    logic [FUEL_W-1:0] fuel;
    logic [PASS_W-1:0] passengers;
    logic [MIN_W-1:0]  minute;
    logic [HOUR_W-1:0] hour;
    logic [KEY_W-1:0]  key;
    logic [ID_W-1:0]   id;
  } skq_entry_t;

  localparam int unsigned ENTRY_W = $bits(skq_entry_t);

  typedef struct packed {
    logic            load;
    logic            emit;
    logic            do_insert;
    logic            do_shift;
    logic [ST_W-1:0] status;
  } skq_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] opcode;
    logic            full;
    logic            empty;
    logic            found;
  } skq_stat_t;

endpackage

FILE: design/skq_ctrl.sv
module skq_ctrl
  import skq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  skq_stat_t stat,
  output skq_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    cmd.status     = ST_OK;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd.emit       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
          case (stat.opcode)
            CMD_INSERT: begin
              if (stat.full) cmd.status = ST_FULL;
              else cmd.do_insert = 1'b1;
            end
            CMD_POP: begin
              if (stat.empty) cmd.status = ST_EMPTY;
              else cmd.do_shift = 1'b1;
            end
            CMD_REMOVE: begin
              if (stat.empty) cmd.status = ST_EMPTY;
              else if (!stat.found) cmd.status = ST_NOT_FOUND;
              else cmd.do_shift = 1'b1;
            end
            default: begin
              cmd.status = ST_OK;
            end
          endcase
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: design/skq_datapath.sv
module skq_datapath
  import skq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  skq_cmd_t         cmd,
  input  logic [OP_W-1:0]  in_op,
  input  skq_entry_t       in_entry,
  output skq_stat_t        stat,
  output logic [ST_W-1:0]  out_status,
  output skq_entry_t       out_entry,
  output logic [CNT_W-1:0] out_count
);

  localparam int unsigned LOG_D = $clog2(QUEUE_DEPTH);

  skq_entry_t             cells [QUEUE_DEPTH];
  skq_entry_t             new_entry;
  logic [OP_W-1:0]        op;
  logic [QUEUE_DEPTH-1:0] gt;
  logic [QUEUE_DEPTH-1:0] match;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;

  logic [QUEUE_DEPTH-1:0] valid;
  logic [QUEUE_DEPTH-1:0] gt_v;
  logic [QUEUE_DEPTH-1:0] sel;
  logic [QUEUE_DEPTH-1:0] shift_mask;
  logic [QUEUE_DEPTH-1:0] match_pre;
  logic [ENTRY_W-1:0]     sel_bits;

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      valid[i] = (CNT_W'(i) < count);
    end
  end

  assign gt_v = gt & valid;

  // first matching cell counted from the head, or the head cell on a pop
  always_comb begin
    match_pre = match & valid;
    for (int s = 0; s < LOG_D; s++) begin
      match_pre = match_pre | (match_pre << (1 << s));
    end
    if (op == CMD_POP) begin
      sel        = {{(QUEUE_DEPTH-1){1'b0}}, valid[0]};
      shift_mask = '1;
    end else begin
      sel        = match & valid & ~(match_pre << 1);
      shift_mask = match_pre;
    end
  end

  always_comb begin
    sel_bits = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      sel_bits = sel_bits | (cells[i] & {ENTRY_W{sel[i]}});
    end
  end

  assign stat.opcode = op;
  assign stat.full   = (count == CNT_W'(QUEUE_DEPTH));
  assign stat.empty  = (count == '0);
  assign stat.found  = |sel;

  always_comb begin
    count_next = count;
    if (cmd.do_insert) count_next = count + CNT_W'(1);
    else if (cmd.do_shift) count_next = count - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op        <= in_op;
      new_entry <= in_entry;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        gt[i]    <= (in_entry.key > cells[i].key);
        match[i] <= (in_entry.id == cells[i].id);
      end
    end
    if (cmd.emit) begin
      out_status <= cmd.status;
      out_entry  <= cmd.do_shift ? skq_entry_t'(sel_bits) : '0;
      out_count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    skq_entry_t from_prev;
    skq_entry_t from_next;
    logic       take_new;

    if (g == 0) begin : g_head
      assign from_prev = new_entry;
      assign take_new  = 1'b1;
    end else begin : g_body
      assign from_prev = cells[g-1];
      assign take_new  = gt_v[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign from_next = cells[g];
    end else begin : g_mid
      assign from_next = cells[g+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.do_insert && !gt_v[g]) begin
        cells[g] <= take_new ? new_entry : from_prev;
      end else if (cmd.do_shift && shift_mask[g]) begin
        cells[g] <= from_next;
      end
    end
  end

endmodule

FILE: design/sorted_key_queue.sv
// channel | dir | tdata (low bit up)                                | tuser
// s_*     | in  | entry_id, sort_key, sched_hour, sched_minute,     | command
//         |     | passengers, fuel_left                             |
// m_*     | out | out_id, out_key, out_hour, out_minute,            | status
//         |     | out_passengers, out_fuel, out_emergency, occupancy |
//
// Each command: a load step registers the key and id compares of all cells,
// then an execute step inserts or shifts the cell array and loads the result.
// One command at a time; the next is taken while the result still waits.
// rst clears the occupancy and the handshake state; cell contents are kept.
// A stalled result holds the array until m_tready frees the output register.
module sorted_key_queue
  import skq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned OUT_W = ((ENTRY_W + CNT_W + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,  // entry_id, sort_key, sched_hour, sched_minute,
                                         // passengers, fuel_left
  input  logic [OP_W-1:0]      s_tuser,  // command
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata,  // out_id, out_key, out_hour, out_minute,
                                         // out_passengers, out_fuel, out_emergency, occupancy
  output logic [ST_W-1:0]      m_tuser   // status
);

  skq_cmd_t         cmd;
  skq_stat_t        stat;
  skq_entry_t       in_entry;
  skq_entry_t       out_entry;
  logic [CNT_W-1:0] out_count;

  assign in_entry.id         = s_tdata[ID_W-1:0];
  assign in_entry.key        = s_tdata[ID_W +: KEY_W];
  assign in_entry.hour       = s_tdata[ID_W+KEY_W +: HOUR_W];
  assign in_entry.minute     = s_tdata[ID_W+KEY_W+HOUR_W +: MIN_W];
  assign in_entry.passengers = s_tdata[ID_W+KEY_W+HOUR_W+MIN_W +: PASS_W];
  assign in_entry.fuel       = s_tdata[ID_W+KEY_W+HOUR_W+MIN_W+PASS_W +: FUEL_W];
  assign in_entry.emergency  = (s_tdata[ID_W+KEY_W+HOUR_W+MIN_W+PASS_W +: FUEL_W] == '0);

  skq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  skq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .CNT_W       (CNT_W)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_op      (s_tuser),
    .in_entry   (in_entry),
    .stat       (stat),
    .out_status (m_tuser),
    .out_entry  (out_entry),
    .out_count  (out_count)
  );

  assign m_tdata = OUT_W'({out_count, out_entry});

endmodule

FILE: design/skq_checker.sv
module skq_checker
  import skq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1),
  parameter int unsigned OUT_W = ((ENTRY_W + CNT_W + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic [ST_W-1:0]  m_tuser
);

  logic [CNT_W-1:0] occ;
  assign occ = m_tdata[ENTRY_W +: CNT_W];

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> occ <= CNT_W'(QUEUE_DEPTH))
    else $error("occupancy beyond depth");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_FULL |-> occ == CNT_W'(QUEUE_DEPTH))
    else $error("full reported below depth");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_EMPTY |-> occ == '0)
    else $error("empty reported with entries held");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tdata[ENTRY_W-1:0] == '0)
    else $error("entry fields set on failed command");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled item changed");

endmodule

bind sorted_key_queue skq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_skq_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
